// ===== rtl/mtfhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtfhc_pkg
// Types and constants shared by the move-to-front handle cache.
// ----------------------------------------------------------------------------
package mtfhc_pkg;

  localparam int ENTRIES   = 32;
  localparam int KEY_W     = 64;
  localparam int ANGLE_W   = 12;
  localparam int HANDLE_W  = 32;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [ANGLE_W-1:0]  angle;
    logic [HANDLE_W-1:0] handle;
    logic                valid;
  } entry_t;

  typedef struct packed {
    logic                load;
    logic                upd;
    logic [KEY_W-1:0]    key;
    logic [ANGLE_W-1:0]  angle;
  } ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/mtfhc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtfhc_cell
// One cache cell: holds an entry, registers its key match, passes the
// hit flag and hit handle down the chain, and shifts in its upstream entry.
// ----------------------------------------------------------------------------
module mtfhc_cell (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire mtfhc_pkg::ctrl_t           ctrl,
  input  wire mtfhc_pkg::entry_t          up_entry,
  input  wire                             hit_in,
  input  wire [mtfhc_pkg::HANDLE_W-1:0]   hacc_in,
  output mtfhc_pkg::entry_t               entry,
  output logic                            hit_out,
  output logic [mtfhc_pkg::HANDLE_W-1:0]  hacc_out
);

  mtfhc_pkg::entry_t entry_r;
  mtfhc_pkg::entry_t entry_nxt;
  logic              match_r;
  logic              match_nxt;

  always_comb begin
    match_nxt = match_r;
    if (ctrl.load) begin
      match_nxt = entry_r.valid && (entry_r.key == ctrl.key) && (entry_r.angle == ctrl.angle);
    end
    entry_nxt = entry_r;
    if (ctrl.upd && !hit_in) begin
      entry_nxt = up_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      entry_r <= '0;
    end else begin
      match_r <= match_nxt;
      entry_r <= entry_nxt;
    end
  end

  assign entry    = entry_r;
  assign hit_out  = hit_in | match_r;
  assign hacc_out = hacc_in | (match_r ? entry_r.handle : '0);

endmodule
`default_nettype wire

// ===== rtl/move_to_front_handle_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// move_to_front_handle_cache
// Fully associative handle cache kept in most-recently-used order.
//
//   channel | direction | fields
//   in_     | input     | font_key, rot_angle, fill_handle
//   out_    | output    | hit, handle_out, evict_valid, evicted_handle
//
// At the accept edge every cell registers its match. In the update state the
// hit chain settles, and on commit the cells up to and including the hit cell
// (every cell on a miss) shift at once; the cells behind it hold. Reset
// clears every valid bit; no clearing pass. in_stall is high in the update
// state; the update waits while the output register is full and stalled.
// ----------------------------------------------------------------------------
module move_to_front_handle_cache (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [mtfhc_pkg::KEY_W-1:0]       in_font_key,
  input  wire [mtfhc_pkg::ANGLE_W-1:0]     in_rot_angle,
  input  wire [mtfhc_pkg::HANDLE_W-1:0]    in_fill_handle,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_hit,
  output logic [mtfhc_pkg::HANDLE_W-1:0]   out_handle_out,
  output logic                             out_evict_valid,
  output logic [mtfhc_pkg::HANDLE_W-1:0]   out_evicted_handle
);

  localparam int N = mtfhc_pkg::ENTRIES;

  mtfhc_pkg::state_t state_r;
  mtfhc_pkg::state_t state_nxt;

  logic [mtfhc_pkg::KEY_W-1:0]    key_r;
  logic [mtfhc_pkg::ANGLE_W-1:0]  angle_r;
  logic [mtfhc_pkg::HANDLE_W-1:0] fill_r;

  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           hit_r;
  logic [mtfhc_pkg::HANDLE_W-1:0] handle_r;
  logic                           ev_r;
  logic [mtfhc_pkg::HANDLE_W-1:0] evh_r;

  mtfhc_pkg::ctrl_t  ctrl;
  mtfhc_pkg::entry_t cell_q  [N];
  mtfhc_pkg::entry_t cell_up [N];
  logic                           hit_chain [N+1];
  logic [mtfhc_pkg::HANDLE_W-1:0] hacc      [N+1];

  logic accept;
  logic commit;
  logic hit;
  logic ev;

  assign accept = in_valid && !in_stall;
  assign commit = (state_r == mtfhc_pkg::S_UPD) && !(out_valid_r && out_stall);
  assign hit    = hit_chain[N];
  assign ev     = !hit && cell_q[N-1].valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtfhc_pkg::S_IDLE: if (accept) state_nxt = mtfhc_pkg::S_UPD;
      mtfhc_pkg::S_UPD:  if (commit) state_nxt = mtfhc_pkg::S_IDLE;
      default:           state_nxt = mtfhc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    ctrl.load  = 1'b0;
    ctrl.upd   = 1'b0;
    ctrl.key   = in_font_key;
    ctrl.angle = in_rot_angle;
    case (state_r)
      mtfhc_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        ctrl.load = in_valid;
      end
      mtfhc_pkg::S_UPD: begin
        ctrl.upd = commit;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (commit)                    out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtfhc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= in_font_key;
      angle_r <= in_rot_angle;
      fill_r  <= in_fill_handle;
    end
    if (commit) begin
      hit_r    <= hit;
      handle_r <= hit ? hacc[N] : fill_r;
      ev_r     <= ev;
      evh_r    <= ev ? cell_q[N-1].handle : '0;
    end
  end

  // new front entry
  assign cell_up[0] = {key_r, angle_r, (hit ? hacc[N] : fill_r), 1'b1};

  assign hit_chain[0] = 1'b0;
  assign hacc[0]      = '0;

  genvar g;
  generate
    for (g = 1; g < N; g++) begin : g_up
      assign cell_up[g] = cell_q[g-1];
    end
    for (g = 0; g < N; g++) begin : g_cell
      mtfhc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .up_entry (cell_up[g]),
        .hit_in   (hit_chain[g]),
        .hacc_in  (hacc[g]),
        .entry    (cell_q[g]),
        .hit_out  (hit_chain[g+1]),
        .hacc_out (hacc[g+1])
      );
    end
  endgenerate

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_handle_out     = handle_r;
  assign out_evict_valid    = ev_r;
  assign out_evicted_handle = evh_r;

endmodule
`default_nettype wire

// ===== verif/tb_move_to_front_handle_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_move_to_front_handle_cache
// Self-checking bench for the MRU-ordered font handle cache. A short table of
// lookups covers the key extremes, angles past 3599, invalid cells and hits
// at depth. A random phase follows, drawing most keys from a pool of
// (key, angle) pairs so hits, deep hits and evictions are all frequent.
// Each result word is compared field by field against the table's word
// or, failing that, an in-bench cache model. Both sides idle at random,
// and the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_move_to_front_handle_cache;

  typedef logic [mtfhc_pkg::ANGLE_W-1:0] angle_t;

  typedef struct packed {
    logic                           hit;
    logic [mtfhc_pkg::HANDLE_W-1:0] handle;
    logic                           evict_valid;
    logic [mtfhc_pkg::HANDLE_W-1:0] evicted;
  } lookup_result_t;

  typedef struct packed {
    logic [mtfhc_pkg::KEY_W-1:0]    key;
    logic [mtfhc_pkg::ANGLE_W-1:0]  angle;
    logic [mtfhc_pkg::HANDLE_W-1:0] fill;
    logic                           typed;
    lookup_result_t                 want;
  } stim_row_t;

  localparam int DIRECTED_N  = 17;
  localparam int RANDOM_N    = 450;
  localparam int POOL_N      = 64;
  localparam int HOLD_CYCLES = 80;

  localparam lookup_result_t NONE = '0;

  // typed = 1: expected word given here; otherwise taken from the model
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{64'h0, 12'd0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{64'h0, 12'd0, 32'h0000_1234, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF, 32'h0, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 12'd3599, 32'h5, 1'b1,
      '{1'b0, 32'h5, 1'b0, 32'h0}},
    '{64'h8000_0000_0000_0000, 12'd3600, 32'hA5A5_A5A5, 1'b1,
      '{1'b0, 32'hA5A5_A5A5, 1'b0, 32'h0}},
    '{64'h8000_0000_0000_0000, 12'd3600, 32'h0, 1'b1,
      '{1'b1, 32'hA5A5_A5A5, 1'b0, 32'h0}},
    '{64'h1, 12'd0, 32'h8000_0000, 1'b1, '{1'b0, 32'h8000_0000, 1'b0, 32'h0}},
    '{64'h0, 12'd1, 32'h7, 1'b1, '{1'b0, 32'h7, 1'b0, 32'h0}},
    '{64'h1, 12'd0, 32'h9, 1'b1, '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    '{64'h5555_5555_5555_5555, 12'hAAA, 32'h5555_5555, 1'b1,
      '{1'b0, 32'h5555_5555, 1'b0, 32'h0}},
    '{64'hAAAA_AAAA_AAAA_AAAA, 12'h555, 32'hAAAA_AAAA, 1'b1,
      '{1'b0, 32'hAAAA_AAAA, 1'b0, 32'h0}},
    '{64'h0, 12'd0, 32'h3, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{64'h7FFF_FFFF_FFFF_FFFF, 12'd2048, 32'hDEAD_BEEF, 1'b0, NONE},
    '{64'h5555_5555_5555_5555, 12'hAAA, 32'h0, 1'b0, NONE},
    '{64'hFFFF_FFFF_FFFF_FFFF, 12'd3599, 32'h1, 1'b0, NONE},
    '{64'h8000_0000_0000_0000, 12'd3600, 32'h2, 1'b0, NONE}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [mtfhc_pkg::KEY_W-1:0]    in_font_key = '0;
  logic [mtfhc_pkg::ANGLE_W-1:0]  in_rot_angle = '0;
  logic [mtfhc_pkg::HANDLE_W-1:0] in_fill_handle = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_hit;
  logic [mtfhc_pkg::HANDLE_W-1:0] out_handle_out;
  logic                           out_evict_valid;
  logic [mtfhc_pkg::HANDLE_W-1:0] out_evicted_handle;

  mtfhc_pkg::entry_t mru_cells [mtfhc_pkg::ENTRIES];
  lookup_result_t    awaited_lookups [$];
  lookup_result_t    oldest;
  int                mismatch_count = 0;
  bit                quiet = 1'b0;
  bit                hold_off_req = 1'b0;

  logic [mtfhc_pkg::KEY_W-1:0]   pool_key [POOL_N];
  logic [mtfhc_pkg::ANGLE_W-1:0] pool_angle [POOL_N];

  move_to_front_handle_cache uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_font_key        (in_font_key),
    .in_rot_angle       (in_rot_angle),
    .in_fill_handle     (in_fill_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_handle_out     (out_handle_out),
    .out_evict_valid    (out_evict_valid),
    .out_evicted_handle (out_evicted_handle)
  );

  always #6 clk = ~clk;

  function automatic lookup_result_t lookup_and_promote(
    input logic [mtfhc_pkg::KEY_W-1:0]    k,
    input logic [mtfhc_pkg::ANGLE_W-1:0]  a,
    input logic [mtfhc_pkg::HANDLE_W-1:0] f
  );
    lookup_result_t r;
    int             found;
    int             i;
    found = -1;
    for (i = 0; i < mtfhc_pkg::ENTRIES; i++) begin
      if (found < 0 && mru_cells[i].valid && mru_cells[i].key == k &&
          mru_cells[i].angle == a) begin
        found = i;
      end
    end
    if (found >= 0) begin
      r = '{1'b1, mru_cells[found].handle, 1'b0, '0};
      for (i = found; i > 0; i--) mru_cells[i] = mru_cells[i-1];
    end else begin
      r.hit         = 1'b0;
      r.handle      = f;
      r.evict_valid = mru_cells[mtfhc_pkg::ENTRIES-1].valid;
      r.evicted     = mru_cells[mtfhc_pkg::ENTRIES-1].valid ?
                      mru_cells[mtfhc_pkg::ENTRIES-1].handle : '0;
      for (i = mtfhc_pkg::ENTRIES - 1; i > 0; i--) mru_cells[i] = mru_cells[i-1];
    end
    mru_cells[0] = '{k, a, r.handle, 1'b1};
    return r;
  endfunction

  task automatic push_word(
    input logic [mtfhc_pkg::KEY_W-1:0]    k,
    input logic [mtfhc_pkg::ANGLE_W-1:0]  a,
    input logic [mtfhc_pkg::HANDLE_W-1:0] f,
    input logic                           typed,
    input lookup_result_t                 want
  );
    lookup_result_t predicted;
    while (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_font_key    <= k;
    in_rot_angle   <= a;
    in_fill_handle <= f;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = lookup_and_promote(k, a, f);
    awaited_lookups.push_back(typed ? want : predicted);
  endtask

  // sender
  initial begin
    int                            n;
    int                            span;
    int                            idx;
    logic [mtfhc_pkg::KEY_W-1:0]   k;
    logic [mtfhc_pkg::ANGLE_W-1:0] a;
    for (n = 0; n < mtfhc_pkg::ENTRIES; n++) mru_cells[n] = '0;
    for (n = 0; n < POOL_N; n++) begin
      pool_key[n]   = {$urandom, $urandom};
      pool_angle[n] = angle_t'($urandom_range(0, 4095));
      // same font at another angle
      if (n % 4 == 1) pool_key[n] = pool_key[n-1];
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_N; n++) begin
      push_word(DIRECTED_ROWS[n].key, DIRECTED_ROWS[n].angle, DIRECTED_ROWS[n].fill,
                DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
    end

    for (n = 0; n < RANDOM_N; n++) begin
      span  = (n < 150) ? 24 : (n < 300) ? 40 : POOL_N;
      quiet = (n >= 180 && n < 280);
      if (n == 100) hold_off_req = 1'b1;
      if ($urandom_range(0, 99) < 75) begin
        idx = $urandom_range(0, span - 1);
        k   = pool_key[idx];
        a   = pool_angle[idx];
      end else begin
        k = {$urandom, $urandom};
        a = angle_t'($urandom_range(0, 4095));
      end
      push_word(k, a, $urandom, 1'b0, NONE);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver stall, with one long hold-off
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0 && out_stall == 1'b0) begin
      if (awaited_lookups.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        oldest = awaited_lookups.pop_front();
        if (out_hit !== oldest.hit) begin
          $error("out_hit: expected %0h, got %0h", oldest.hit, out_hit);
          mismatch_count++;
        end
        if (out_handle_out !== oldest.handle) begin
          $error("out_handle_out: expected %0h, got %0h", oldest.handle, out_handle_out);
          mismatch_count++;
        end
        if (out_evict_valid !== oldest.evict_valid) begin
          $error("out_evict_valid: expected %0h, got %0h", oldest.evict_valid,
                 out_evict_valid);
          mismatch_count++;
        end
        if (out_evicted_handle !== oldest.evicted) begin
          $error("out_evicted_handle: expected %0h, got %0h", oldest.evicted,
                 out_evicted_handle);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
